// ===== hdl/btha_pkg.sv =====
// Shared types and constants for the boundary-tag heap allocator.
// No dependencies; imported by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package btha_pkg;

  localparam int HEADER_BYTES = 3;
  localparam int CFG_W        = 11;
  localparam int DSIZE_W      = 10;
  localparam int ADDR_W       = 10;
  localparam int FSIZE_W      = 11;
  localparam int TDATA_W      = 24;
  localparam int MIN_RESET    = 16;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_MEMORY,
    ST_NOT_ALLOCATED
  } status_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_WALK,
    OP_RM1,
    OP_RM2,
    OP_SPLIT,
    OP_PUSH1,
    OP_PUSH2,
    OP_AMARK,
    OP_FHDR,
    OP_FRIGHT,
    OP_FTAG,
    OP_FLEFT,
    OP_FLEFTM,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_kind;
    logic kind;
    logic head_nil;
    logic start_bad;
    logic fit;
    logic walk_stop;
    logic mark_set;
    logic right_ok;
    logic start_zero;
    logic left_ok;
    logic rest_small;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

// ===== hdl/btha_ctrl.sv =====
// Heap allocator sequencer: walks allocate and free requests one step
// per cycle unless stalled. Uses btha_pkg; drives btha_dp by command.
`timescale 1ns / 1ps
`default_nettype none

module btha_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  btha_pkg::flags_t flags,
  output btha_pkg::cmd_t   cmd
);
  import btha_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_RM1, S_RM2, S_SPLIT, S_PUSH1, S_PUSH2,
    S_AMARK, S_FHDR, S_FRIGHT, S_FTAG, S_FLEFT, S_FLEFTM, S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_SPLIT, RET_FTAG, RET_PUSH} ret_t;

  state_t state;
  ret_t   ret;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   cmd.op = s_tvalid ? OP_LOAD : OP_IDLE;
      S_WALK:   cmd.op = OP_WALK;
      S_RM1:    cmd.op = OP_RM1;
      S_RM2:    cmd.op = OP_RM2;
      S_SPLIT:  cmd.op = OP_SPLIT;
      S_PUSH1:  cmd.op = OP_PUSH1;
      S_PUSH2:  cmd.op = OP_PUSH2;
      S_AMARK:  cmd.op = OP_AMARK;
      S_FHDR:   cmd.op = OP_FHDR;
      S_FRIGHT: cmd.op = OP_FRIGHT;
      S_FTAG:   cmd.op = OP_FTAG;
      S_FLEFT:  cmd.op = OP_FLEFT;
      S_FLEFTM: cmd.op = OP_FLEFTM;
      S_DONE:   cmd.op = OP_DONE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret   <= RET_SPLIT;
    end else begin
      unique case (state)
        S_CLEAR: if (flags.clr_last) state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            if (!flags.in_kind) state <= flags.head_nil ? S_DONE : S_WALK;
            else                state <= flags.start_bad ? S_DONE : S_FHDR;
          end
        end
        S_WALK: begin
          if (flags.fit) begin
            ret   <= RET_SPLIT;
            state <= S_RM1;
          end else if (flags.walk_stop) begin
            state <= S_DONE;
          end
        end
        S_RM1: state <= S_RM2;
        S_RM2: begin
          unique case (ret)
            RET_SPLIT: state <= S_SPLIT;
            RET_FTAG:  state <= S_FTAG;
            default:   state <= S_PUSH1;
          endcase
        end
        S_SPLIT: state <= flags.rest_small ? S_AMARK : S_PUSH1;
        S_PUSH1: state <= S_PUSH2;
        S_PUSH2: state <= flags.kind ? S_DONE : S_AMARK;
        S_AMARK: state <= S_DONE;
        S_FHDR: begin
          if (!flags.mark_set)    state <= S_DONE;
          else if (flags.right_ok) state <= S_FRIGHT;
          else                    state <= S_FTAG;
        end
        S_FRIGHT: begin
          if (!flags.mark_set) begin
            ret   <= RET_FTAG;
            state <= S_RM1;
          end else begin
            state <= S_FTAG;
          end
        end
        S_FTAG:  state <= flags.start_zero ? S_PUSH1 : S_FLEFT;
        S_FLEFT: state <= flags.left_ok ? S_FLEFTM : S_PUSH1;
        S_FLEFTM: begin
          if (!flags.mark_set) begin
            ret   <= RET_PUSH;
            state <= S_RM1;
          end else begin
            state <= S_PUSH1;
          end
        end
        S_DONE: if (flags.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/btha_dp.sv =====
// Datapath of the heap allocator: block stores, free list registers,
// arithmetic and the result register. Depends on btha_pkg; run by btha_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module btha_dp #(
  parameter int HEAP_BYTES     = 1024,
  parameter int OVERHEAD_BYTES = 5
) (
  input  wire                              clk,
  input  wire                              rst,
  input  btha_pkg::cmd_t                   cmd,
  output btha_pkg::flags_t                 flags,
  input  wire                              s_tuser,
  input  wire  [btha_pkg::TDATA_W-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [btha_pkg::TDATA_W-1:0]     m_tdata,
  input  wire                              cfg_valid,
  input  wire  [btha_pkg::CFG_W-1:0]       cfg_data
);
  import btha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int NW = ((SW > CFG_W) ? SW : CFG_W) + 2;
  localparam logic [NW-1:0] HEAP_N = NW'(HEAP_BYTES);
  localparam logic [SW-1:0] NIL    = SW'(HEAP_BYTES);

  // block stores
  logic [SW-1:0] hdr_mem  [HEAP_BYTES];
  logic          mark_mem [HEAP_BYTES];
  logic [SW-1:0] tag_mem  [HEAP_BYTES];
  logic [SW-1:0] next_mem [HEAP_BYTES];
  logic [SW-1:0] prev_mem [HEAP_BYTES];

  logic [SW-1:0] hdr_rd, tag_rd, next_rd, prev_rd;
  logic          mark_rd;

  logic          hdr_we, mark_we, tag_we, next_we, prev_we;
  logic [NW-1:0] hdr_wa, mark_wa, tag_wa, next_wa, prev_wa;
  logic [SW-1:0] hdr_wd, tag_wd, next_wd, prev_wd;
  logic          mark_wd;

  logic [NW-1:0] raddr, raddr_next;

  logic [SW-1:0]    head;
  logic [AW-1:0]    clr_cnt;
  logic [CFG_W-1:0] min_reg;
  logic             kind_r;
  logic [NW-1:0]    need, have, cur, size_r, start_r, mstart, rnode;
  logic [SW-1:0]    visits, p_r, n_r;
  status_t          status_r;
  logic [ADDR_W-1:0]  daddr_r;
  logic [FSIZE_W-1:0] fsize_r;

  // derived values
  logic [CFG_W-1:0] minsz;
  logic [NW-1:0]    minsz_n, need_in, start_in, hdr_n, tag_n, next_n;
  logic [NW-1:0]    right_sum, pnode, psize, ptag_last, atag_last;
  logic [DSIZE_W-1:0] dsize_in;
  logic [ADDR_W-1:0]  addr_in;
  logic          head_ok, p_ok, n_ok, push_skip, ptag_ok, atag_ok;

  assign dsize_in = s_tdata[DSIZE_W-1:0];
  assign addr_in  = s_tdata[DSIZE_W +: ADDR_W];
  assign minsz    = (min_reg == '0) ? CFG_W'(1) : min_reg;
  assign minsz_n  = NW'(minsz);
  assign need_in  = ((NW'(dsize_in) + NW'(OVERHEAD_BYTES)) < minsz_n) ? minsz_n
                  : (NW'(dsize_in) + NW'(OVERHEAD_BYTES));
  assign start_in = NW'(addr_in) - NW'(HEADER_BYTES);
  assign hdr_n    = NW'(hdr_rd);
  assign tag_n    = NW'(tag_rd);
  assign next_n   = NW'(next_rd);
  assign right_sum = start_r + hdr_n;

  assign head_ok = (head < NIL);
  assign p_ok    = (p_r < NIL);
  assign n_ok    = (n_r < NIL);

  // push target: split remainder on allocate, merged block on free
  assign pnode     = kind_r ? mstart : cur + need;
  assign psize     = kind_r ? size_r : have - need;
  assign push_skip = (pnode >= HEAP_N);
  assign ptag_last = pnode + psize - NW'(1);
  assign ptag_ok   = (psize != '0) && (ptag_last < HEAP_N);
  assign atag_last = cur + need - NW'(1);
  assign atag_ok   = (need != '0) && (atag_last < HEAP_N);

  always_comb begin
    flags.clr_last   = (clr_cnt == AW'(HEAP_BYTES - 1));
    flags.in_kind    = s_tuser;
    flags.kind       = kind_r;
    flags.head_nil   = !head_ok;
    flags.start_bad  = (addr_in < ADDR_W'(HEADER_BYTES)) || (start_in >= HEAP_N);
    flags.fit        = (hdr_n >= need);
    flags.walk_stop  = (next_n >= HEAP_N) || ((NW'(visits) + NW'(1)) >= HEAP_N);
    flags.mark_set   = mark_rd;
    flags.right_ok   = (hdr_rd != '0) && (right_sum < HEAP_N);
    flags.start_zero = (start_r == '0);
    flags.left_ok    = (tag_rd != '0) && (tag_n <= start_r);
    flags.rest_small = ((have - need) < minsz_n);
    flags.out_free   = !m_tvalid || m_tready;
  end

  // read address for the next cycle; all stores read at the same place
  always_comb begin
    raddr_next = raddr;
    case (cmd.op)
      OP_LOAD:  raddr_next = s_tuser ? start_in : NW'(head);
      OP_WALK:  if (!flags.fit) raddr_next = next_n;
      OP_FHDR:  raddr_next = right_sum;
      OP_FTAG:  raddr_next = start_r - NW'(1);
      OP_FLEFT: raddr_next = start_r - tag_n;
      default:  raddr_next = raddr;
    endcase
  end

  // store writes
  always_comb begin
    hdr_we = 1'b0;  hdr_wa = '0;  hdr_wd = '0;
    mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0;
    tag_we = 1'b0;  tag_wa = '0;  tag_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        hdr_we  = 1'b1; hdr_wa  = NW'(clr_cnt);
        hdr_wd  = (clr_cnt == '0) ? NIL : '0;
        mark_we = 1'b1; mark_wa = NW'(clr_cnt);
        tag_we  = 1'b1; tag_wa  = NW'(clr_cnt);
        tag_wd  = flags.clr_last ? NIL : '0;
        next_we = 1'b1; next_wa = NW'(clr_cnt); next_wd = NIL;
        prev_we = 1'b1; prev_wa = NW'(clr_cnt); prev_wd = NIL;
      end
      OP_RM1: begin
        next_we = p_ok; next_wa = NW'(p_r); next_wd = n_r;
        prev_we = n_ok; prev_wa = NW'(n_r); prev_wd = p_ok ? p_r : NIL;
      end
      OP_RM2: begin
        next_we = 1'b1; next_wa = rnode; next_wd = NIL;
        prev_we = 1'b1; prev_wa = rnode; prev_wd = NIL;
      end
      OP_PUSH1: begin
        hdr_we  = !push_skip; hdr_wa = pnode; hdr_wd = SW'(psize);
        mark_we = !push_skip; mark_wa = pnode;
        tag_we  = !push_skip && ptag_ok; tag_wa = ptag_last; tag_wd = SW'(psize);
        prev_we = !push_skip; prev_wa = pnode; prev_wd = NIL;
        next_we = !push_skip; next_wa = pnode; next_wd = head_ok ? head : NIL;
      end
      OP_PUSH2: begin
        prev_we = !push_skip && head_ok; prev_wa = NW'(head);
        prev_wd = SW'(pnode);
      end
      OP_AMARK: begin
        hdr_we  = 1'b1; hdr_wa = cur; hdr_wd = SW'(need);
        mark_we = 1'b1; mark_wa = cur; mark_wd = 1'b1;
        tag_we  = atag_ok; tag_wa = atag_last; tag_wd = SW'(need);
      end
      OP_FHDR: begin
        mark_we = mark_rd; mark_wa = start_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hdr_we)  hdr_mem[hdr_wa[AW-1:0]]   <= hdr_wd;
    if (mark_we) mark_mem[mark_wa[AW-1:0]] <= mark_wd;
    if (tag_we)  tag_mem[tag_wa[AW-1:0]]   <= tag_wd;
    if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[AW-1:0]] <= prev_wd;
    hdr_rd  <= hdr_mem[raddr_next[AW-1:0]];
    mark_rd <= mark_mem[raddr_next[AW-1:0]];
    tag_rd  <= tag_mem[raddr_next[AW-1:0]];
    next_rd <= next_mem[raddr_next[AW-1:0]];
    prev_rd <= prev_mem[raddr_next[AW-1:0]];
    raddr   <= raddr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      clr_cnt  <= '0;
      min_reg  <= CFG_W'(MIN_RESET);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) min_reg <= cfg_data;
      if ((cmd.op == OP_DONE) && flags.out_free) m_tvalid <= 1'b1;
      else if (m_tready)                         m_tvalid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        OP_LOAD: begin
          kind_r   <= s_tuser;
          need     <= need_in;
          cur      <= NW'(head);
          visits   <= '0;
          start_r  <= start_in;
          mstart   <= start_in;
          daddr_r  <= '0;
          fsize_r  <= '0;
          if (!s_tuser && !head_ok)         status_r <= ST_NO_MEMORY;
          else if (s_tuser && flags.start_bad) status_r <= ST_NOT_ALLOCATED;
          else                              status_r <= ST_OK;
        end
        OP_WALK: begin
          if (flags.fit) begin
            have  <= hdr_n;
            rnode <= raddr;
            p_r   <= prev_rd;
            n_r   <= next_rd;
          end else begin
            cur    <= next_n;
            visits <= visits + SW'(1);
            if (flags.walk_stop) status_r <= ST_NO_MEMORY;
          end
        end
        OP_RM1: if (!p_ok) head <= n_ok ? n_r : NIL;
        OP_SPLIT: if (flags.rest_small) need <= have;
        OP_PUSH2: begin
          if (!push_skip) head <= SW'(pnode);
          if (kind_r) fsize_r <= psize[FSIZE_W-1:0];
        end
        OP_AMARK: daddr_r <= ADDR_W'(cur + NW'(HEADER_BYTES));
        OP_FHDR: begin
          if (!mark_rd) status_r <= ST_NOT_ALLOCATED;
          size_r <= hdr_n;
        end
        OP_FRIGHT: begin
          if (!mark_rd) begin
            size_r <= size_r + hdr_n;
            rnode  <= raddr;
            p_r    <= prev_rd;
            n_r    <= next_rd;
          end
        end
        OP_FLEFTM: begin
          if (!mark_rd) begin
            size_r <= size_r + hdr_n;
            mstart <= raddr;
            rnode  <= raddr;
            p_r    <= prev_rd;
            n_r    <= next_rd;
          end
        end
        OP_DONE: begin
          if (flags.out_free) m_tdata <= {1'b0, fsize_r, daddr_r, status_r};
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NIL) else $error("free list head out of range");
  a_alloc_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_AMARK) |-> (need <= have)) else $error("allocated more than block");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |=> (cmd.op != OP_LOAD && cmd.op != OP_IDLE))
    else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/boundary_tag_heap_allocator.sv =====
// Top level of the first-fit boundary-tag heap allocator.
// Depends on btha_pkg, btha_ctrl and btha_dp.
//
// Usage:
//   s_* : request stream. s_tuser = kind (0 allocate, 1 free).
//         s_tdata = data_size[9:0], block_address[19:10], zero pad.
//   m_* : one result per request. m_tdata = status[1:0],
//         data_address[11:2], freed_size[22:12], zero pad.
//   cfg : min_block_size write, always ready; write only while idle.
// Allocate walks the free list (the first-fit walk reads one block per
//   cycle from the block stores), unlinks the first block that fits, pushes
//   back a split-off remainder unless too small, and marks the block
//   allocated. Free checks the header, merges any free neighbors
//   and pushes the merged block. A failed walk, an empty list or a rejected
//   free goes straight to its result. One request at a time; the next can
//   be taken the cycle after its result is loaded into the output register.
// Reset: a clearing pass writes the block stores for HEAP_BYTES cycles,
//   during which s_tready stays low; configuration writes are still taken.
// Stall: a held result keeps its request in the final step; s_tready
//   stays low until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES     = 1024,
  parameter int OVERHEAD_BYTES = 5
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [btha_pkg::TDATA_W-1:0] s_tdata,  // data_size, block_address
  input  wire                          s_tuser,  // kind
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [btha_pkg::TDATA_W-1:0] m_tdata,  // status, data_address, freed_size
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [btha_pkg::CFG_W-1:0]   cfg_data
);
  import btha_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  assign cfg_ready = 1'b1;

  btha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  btha_dp #(
    .HEAP_BYTES     (HEAP_BYTES),
    .OVERHEAD_BYTES (OVERHEAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .flags     (flags),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
